### hdl/half_pixel_reference_interpolation_core_assert.svh
// Assertion macros for the half-pixel reference interpolation core.
// Used by the top level; needs no package. Empty when SYNTHESIS is defined.
`ifndef HALF_PIXEL_REFERENCE_INTERPOLATION_CORE_ASSERT_SVH
`define HALF_PIXEL_REFERENCE_INTERPOLATION_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge out of reset.
`define HPRI_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("hpri assertion failed");

// An antecedent in one cycle implies a consequent in the same cycle.
`define HPRI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpri implication failed");

// An antecedent in one cycle implies a consequent in the next cycle.
`define HPRI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpri next-cycle implication failed");

`else

`define HPRI_ASSERT(label, clk, rst_n, expr)
`define HPRI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HPRI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/hpri_pkg.sv
// Shared types and constants for the half-pixel reference interpolation core.
// Used by the line store RAM and the top level; depends on nothing.
package hpri_pkg;

    // Largest supported row length and the widths that follow from it.
    localparam int MAX_LINE_WIDTH = 2048;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int CFG_W          = 12;
    localparam int CNT_W          = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int PIX_W          = 8;
    localparam int OUT_DATA_W     = 3 * PIX_W;

    // Register reset value: the full line store width.
    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = CFG_W'(MAX_LINE_WIDTH);

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [COL_W-1:0] col_t;

endpackage

### hdl/half_pixel_reference_interpolation_core.sv
// Half-pixel reference interpolation: up, left and diagonal floor averages per pixel.
// Depends on hpri_pkg, hpri_line_ram and the assertion macro header.
//
//   Channel   Direction  Signals                         Content
//   s_axis    in         tvalid tready tdata[7:0] tuser  pixel / frame_start
//   m_axis    out        tvalid tready tdata[23:0]       up_avg, left_avg, diag_avg
//   cfg       in         cfg_wr_en cfg_wr_data[11:0]     line_width
//
// One item per clock sustained while the output is not stalled; an accepted item passes the
// compute stage registers, beside the registered line store read, and then the result register.
// Reset clears the column, the first-row flag and the neighbor samples; the line store
// is not cleared, since the first row after reset does not use what is read from it.
// A stalled output holds the result register and the compute stage, which then stops input.
module half_pixel_reference_interpolation_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [hpri_pkg::CFG_W-1:0]       cfg_wr_data,     // line_width
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [hpri_pkg::PIX_W-1:0]       s_axis_tdata,    // [7:0] pixel
    input  logic                             s_axis_tuser,    // [0] frame_start
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [hpri_pkg::OUT_DATA_W-1:0]  m_axis_tdata     // [7:0] up, [15:8] left, [23:16] diag
);
    import hpri_pkg::*;

`include "half_pixel_reference_interpolation_core_assert.svh"

    logic [CFG_W-1:0] line_width_reg;
    col_t             col_reg;
    col_t             col_next;
    logic             first_row_reg;
    logic             first_row_next;

    logic             s1_valid_reg;
    pix_t             s1_pixel_reg;
    col_t             s1_col_reg;
    logic             s1_first_reg;
    pix_t             left_reg;
    pix_t             ul_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic             in_acc;
    logic             s1_adv;
    col_t             cur_col;
    logic             cur_first;
    logic [CNT_W-1:0] eff_width;
    logic [CNT_W-1:0] col_inc;
    pix_t             above;

    // Handshake: the compute stage moves on when the result register is free.
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            line_width_reg <= cfg_wr_data;
        end
    end

    // Effective row length: zero acts as one, and it is capped at the line store size.
    always_comb
    begin
        eff_width = CNT_W'(line_width_reg);
        if (line_width_reg == '0)
        begin
            eff_width = CNT_W'(1);
        end
        else if (CNT_W'(line_width_reg) > CNT_W'(MAX_LINE_WIDTH))
        begin
            eff_width = CNT_W'(MAX_LINE_WIDTH);
        end
    end

    // Position of the incoming item and the position that follows it.
    always_comb
    begin
        cur_col        = s_axis_tuser ? '0 : col_reg;
        cur_first      = s_axis_tuser || first_row_reg;
        col_inc        = CNT_W'(cur_col) + CNT_W'(1);
        col_next       = col_inc[COL_W-1:0];
        first_row_next = cur_first;
        if (col_inc >= eff_width)
        begin
            col_next       = '0;
            first_row_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end
        else if (in_acc)
        begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
        end
    end

    // Line store: read the pixel above on accept, write the pixel back in the compute stage.
    hpri_line_ram u_line_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (in_acc),
        .rd_addr (cur_col),
        .rd_data (above)
    );

    // Compute stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pixel_reg <= s_axis_tdata;
            s1_col_reg   <= cur_col;
            s1_first_reg <= cur_first;
        end
    end

    // Left and upper-left samples advance as each item leaves the compute stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            ul_reg   <= '0;
        end
        else if (s1_adv)
        begin
            left_reg <= s1_pixel_reg;
            ul_reg   <= above;
        end
    end

    // Floor averages with the edge fallbacks.
    always_comb
    begin
        logic [PIX_W:0]   up_sum;
        logic [PIX_W:0]   left_sum;
        logic [PIX_W+1:0] quad_sum;
        pix_t             up_v;
        pix_t             left_v;
        pix_t             diag_v;

        up_sum   = {1'b0, s1_pixel_reg} + {1'b0, above};
        left_sum = {1'b0, s1_pixel_reg} + {1'b0, left_reg};
        quad_sum = {2'b00, s1_pixel_reg} + {2'b00, left_reg}
                 + {2'b00, ul_reg} + {2'b00, above};
        up_v     = s1_first_reg ? s1_pixel_reg : up_sum[PIX_W:1];
        left_v   = (s1_col_reg == '0) ? s1_pixel_reg : left_sum[PIX_W:1];
        if (s1_first_reg)
        begin
            diag_v = left_v;
        end
        else if (s1_col_reg == '0)
        begin
            diag_v = up_v;
        end
        else
        begin
            diag_v = quad_sum[PIX_W+1:2];
        end
        out_data_next = {diag_v, left_v, up_v};
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A held compute stage must block new input.
    `HPRI_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, s1_valid_reg && !s1_adv, !s_axis_tready)
    // A new result only appears after the compute stage held an item.
    `HPRI_ASSERT_IMP(a_result_from_stage, clk, rst_n, $rose(m_axis_tvalid), $past(s1_valid_reg))
    // The first-row flag only clears on an accepted item that wraps the row.
    `HPRI_ASSERT_IMP(a_first_row_clears_on_wrap, clk, rst_n, $fell(first_row_reg), $past(in_acc) && (col_reg == '0))
    // With a one-pixel row every item sits in column zero.
    `HPRI_ASSERT_NEXT(a_single_column, clk, rst_n, in_acc && (eff_width == CNT_W'(1)), col_reg == '0)

endmodule

### hdl/hpri_line_ram.sv
// Line store for the previous row: one write and one read port, registered read.
// Depends on hpri_pkg. A read of the address written in the same cycle returns the new data.
module hpri_line_ram (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  hpri_pkg::col_t wr_addr,
    input  hpri_pkg::pix_t wr_data,
    input  logic          rd_en,
    input  hpri_pkg::col_t rd_addr,
    output hpri_pkg::pix_t rd_data
);
    import hpri_pkg::*;

    pix_t line_mem [MAX_LINE_WIDTH];
    pix_t mem_q_reg;
    pix_t bypass_data_reg;
    logic bypass_reg;

    // Storage array with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= line_mem[rd_addr];
        end
    end

    // Capture the write data on every read; it is used when the read hits the entry being written.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            bypass_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            bypass_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = bypass_reg ? bypass_data_reg : mem_q_reg;

endmodule

### dv/hpri_checker.sv
// Checker for the half-pixel reference interpolation core: predicts and compares results.
// Watches the pixel, result and width-write channels; depends on hpri_pkg.
`timescale 1ns / 100ps

module hpri_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [hpri_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [hpri_pkg::PIX_W-1:0]      s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [hpri_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                              accepted_items,
    output int                              checked_results,
    output int                              mismatch_count
);
    import hpri_pkg::*;

    // One result item, packed in the same order as the output tdata.
    typedef struct packed {
        pix_t diag;
        pix_t left;
        pix_t up;
    } half_pel_t;

    // Shadow of the block's state: previous row, neighbor samples, position and width.
    pix_t             prev_row [0:MAX_LINE_WIDTH-1];
    pix_t             left_px;
    pix_t             upleft_px;
    int unsigned      col_pos;
    logic             top_row;
    logic [CFG_W-1:0] width_reg;

    // Results predicted but not yet seen on the output.
    half_pel_t half_pel_due [$];

    // Row length that the block actually uses for a register value.
    function automatic int unsigned row_length(input logic [CFG_W-1:0] w);
        if (w == '0)
            return 1;
        if (w > MAX_LINE_WIDTH)
            return MAX_LINE_WIDTH;
        return int'(w);
    endfunction

    // Computes the three averages for one pixel and advances the shadow state.
    function automatic half_pel_t interpolate(input pix_t px, input logic frame_mark);
        half_pel_t   r;
        pix_t        above;
        int unsigned sum;
        if (frame_mark)
        begin
            col_pos = 0;
            top_row = 1'b1;
        end
        above = prev_row[col_pos];

        r.up   = top_row ? px : pix_t'((int'(px) + int'(above)) >> 1);
        r.left = (col_pos == 0) ? px : pix_t'((int'(px) + int'(left_px)) >> 1);
        if (!top_row && col_pos != 0)
        begin
            sum    = int'(px) + int'(left_px) + int'(upleft_px) + int'(above);
            r.diag = pix_t'(sum >> 2);
        end
        else if (top_row)
            r.diag = r.left;
        else
            r.diag = r.up;

        upleft_px         = above;
        prev_row[col_pos] = px;
        left_px           = px;

        // Wrap at the end of the row; the first row ends there too.
        col_pos++;
        if (col_pos >= row_length(width_reg))
        begin
            col_pos = 0;
            top_row = 1'b0;
        end
        return r;
    endfunction

    // Compare results first, then predict for a newly accepted pixel, then take a width write.
    always @(posedge clk or negedge rst_n)
    begin
        half_pel_t want;
        half_pel_t got;
        half_pel_t next_due;
        if (!rst_n)
        begin
            left_px         = '0;
            upleft_px       = '0;
            col_pos         = 0;
            top_row         = 1'b1;
            width_reg       = LINE_WIDTH_RESET;
            half_pel_due.delete();
            accepted_items  <= 0;
            checked_results <= 0;
            mismatch_count  <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                checked_results <= checked_results + 1;
                if (half_pel_due.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    $display("%0t: result with nothing expected: up=%0d left=%0d diag=%0d",
                             $time, got.up, got.left, got.diag);
                end
                else
                begin
                    want = half_pel_due.pop_front();
                    if (got.up !== want.up || got.left !== want.left
                        || got.diag !== want.diag)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        $display({"%0t: mismatch: expected up=%0d left=%0d diag=%0d,",
                                  " actual up=%0d left=%0d diag=%0d"},
                                 $time, want.up, want.left, want.diag,
                                 got.up, got.left, got.diag);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                next_due     = interpolate(s_axis_tdata, s_axis_tuser);
                half_pel_due = {half_pel_due, next_due};
                accepted_items <= accepted_items + 1;
            end
            if (cfg_wr_en)
                width_reg = cfg_wr_data;
        end
    end

endmodule

### dv/testbench.sv
// Top of the testbench for the half-pixel reference interpolation core.
// Drives pixels, width writes and output stalls; hpri_checker does the checking.
`timescale 1ns / 100ps

module testbench;
    import hpri_pkg::*;

    localparam int LIMIT_CYCLES   = 600000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 60;
    localparam int OVERSIZE_ITEMS = 150;

    typedef enum {GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH} gap_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]      cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata = '0;      // [7:0] pixel
    logic                  s_axis_tuser = 1'b0;    // [0] frame_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;           // [7:0] up, [15:8] left, [23:16] diag

    int               accepted_items;
    int               checked_results;
    int               mismatch_count;
    int               cycle_count = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    logic             frame_mark_due = 1'b0;
    logic [CFG_W-1:0] width_now = LINE_WIDTH_RESET;
    int               width_writes = 0;

    half_pixel_reference_interpolation_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hpri_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .accepted_items  (accepted_items),
        .checked_results (checked_results),
        .mismatch_count  (mismatch_count)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output stalls at the rate of the current phase.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[half_pixel_reference_interpolation_core] ERROR");
            $finish;
        end
    end

    function automatic int unsigned row_length(input logic [CFG_W-1:0] w);
        if (w == '0)
            return 1;
        if (w > MAX_LINE_WIDTH)
            return MAX_LINE_WIDTH;
        return int'(w);
    endfunction

    // Pixel values that lean toward the extremes now and then.
    function automatic pix_t rand_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return pix_t'($urandom_range(0, 255));
    endfunction

    task automatic apply_gaps(input gap_mode_t mode);
        case (mode)
            GAPS_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            GAPS_SENDER:   begin send_idle_pct = 66; recv_stall_pct = 0;  end
            GAPS_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default:       begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        endcase
    endtask

    // Sends one pixel item and returns at the edge where it is accepted.
    task automatic push_pixel(input pix_t px, input logic frame_mark);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid  <= 1'b1;
        s_axis_tdata   <= px;
        s_axis_tuser   <= frame_mark | frame_mark_due;
        frame_mark_due = 1'b0;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drops valid and waits until every result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (accepted_items != checked_results)
            @(posedge clk);
    endtask

    // Writes the row width while idle. A wider row than before restarts the frame, so
    // that no column of the line store is read before it was written.
    task automatic write_width(input logic [CFG_W-1:0] w);
        if (row_length(w) > row_length(width_now))
            frame_mark_due = 1'b1;
        width_now   = w;
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        width_writes++;
    endtask

    initial
    begin
        logic [CFG_W-1:0] w;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no frame mark after reset, at the reset width.
        apply_gaps(GAPS_NONE);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd128, 1'b0);
        drain();

        // Shrink below the current column: the first row ends after the next pixel.
        write_width(12'd3);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd0, 1'b0);
        // New frame with all-ones content for the largest sums.
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0);
        drain();

        // Zero width acts as one pixel per row: every pixel is in the first column.
        write_width(12'd0);
        push_pixel(8'd7, 1'b0);
        push_pixel(8'd200, 1'b0);
        push_pixel(8'd13, 1'b0);
        drain();

        // Alternating extremes in a two-pixel row for the odd sums.
        write_width(12'd2);
        push_pixel(8'd1, 1'b0);
        push_pixel(8'd254, 1'b0);
        push_pixel(8'd254, 1'b0);
        push_pixel(8'd1, 1'b0);
        drain();

        // Width above the store size acts as the full store.
        apply_gaps(GAPS_BOTH);
        write_width(12'hFFF);
        for (int i = 0; i < OVERSIZE_ITEMS; i++)
            push_pixel(rand_pixel(), 1'b0);
        drain();

        // Random phases, each under its own width and gap pattern.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 7))
                0:       w = 12'd0;
                1:       w = 12'd1;
                2:       w = 12'd2048;
                default: w = CFG_W'($urandom_range(1, 12));
            endcase
            apply_gaps(gap_mode_t'(ph % 4));
            write_width(w);
            for (int i = 0; i < PHASE_ITEMS; i++)
                push_pixel(rand_pixel(), ($urandom_range(0, 39) == 0));
            drain();
        end
        repeat (4) @(posedge clk);

        $display("Sent %0d pixels and checked %0d results over %0d width settings,",
                 accepted_items, checked_results, width_writes);
        $display("including zero, one, two, the full store and an oversized width.");
        if (mismatch_count == 0 && accepted_items == checked_results)
            $display("[half_pixel_reference_interpolation_core] OK");
        else
            $display("[half_pixel_reference_interpolation_core] ERROR");
        $finish;
    end

endmodule
